[src/hsl_to_rgb_converter_unit_macros.svh]
// Assertion macros shared by the HSL to RGB converter modules.
// No dependencies; included by the files that carry assertions.
`ifndef HSL_TO_RGB_CONVERTER_UNIT_MACROS_SVH
`define HSL_TO_RGB_CONVERTER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define HSL2RGB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define HSL2RGB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/hsl2rgb_pkg.sv]
// Shared types and constants of the HSL to RGB converter.
// No dependencies; used by the interfaces and every module.
package hsl2rgb_pkg;

    // Field widths
    localparam int HUE_W = 13;
    localparam int CH_W  = 8;
    localparam int P_W   = 16;   // (255 * (1 - |2l - 1|)) * s, at most 64770
    localparam int TRI_W = 10;   // triangle position 0..960
    localparam int NUM_W = 27;   // numerators over the common denominator

    // Hue geometry in sixteenths of a degree
    localparam logic [HUE_W-1:0] HUE_FULL   = HUE_W'(5760);
    localparam logic [HUE_W-1:0] HUE_SECTOR = HUE_W'(960);
    localparam logic [HUE_W-1:0] HUE_PAIR   = HUE_W'(1920);

    // Channel divisor and its reciprocal: q ~= (v * RECIP_K) >> RECIP_SHIFT
    localparam int DIV_W       = 19;
    localparam int RECIP_W     = 18;
    localparam int RECIP_SHIFT = 36;
    localparam logic [DIV_W-1:0]   CH_DIVISOR = DIV_W'(489600);
    localparam logic [RECIP_W-1:0] RECIP_K    = RECIP_W'(140358);

    // Pipeline depth
    localparam int NUM_STAGES = 5;

    // Sixty-degree hue sectors
    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } sector_t;

    // Per-stage load enables and occupancy
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] full;
    } pipe_ctl_t;

endpackage

[src/hsl2rgb_in_if.sv]
// Input channel of the HSL to RGB converter: valid/ready plus one HSL item.
// Depends on hsl2rgb_pkg for field widths.
interface hsl2rgb_in_if import hsl2rgb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  saturation;
    logic [CH_W-1:0]  lightness;

    modport source (output valid, output hue, output saturation, output lightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input lightness,
                    output ready);
endinterface

[src/hsl2rgb_out_if.sv]
// Output channel of the HSL to RGB converter: valid/ready plus one RGB item.
// Depends on hsl2rgb_pkg for field widths.
interface hsl2rgb_out_if import hsl2rgb_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;

    modport source (output valid, output red, output green, output blue,
                    input ready);
    modport sink   (input valid, input red, input green, input blue,
                    output ready);
endinterface

[src/hsl2rgb_pipe_ctl.sv]
// Pipeline control: occupancy bits and per-stage load enables with back-pressure.
// Depends on hsl2rgb_pkg and the assertion macro header.
`include "hsl_to_rgb_converter_unit_macros.svh"

module hsl2rgb_pipe_ctl import hsl2rgb_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output pipe_ctl_t pipe
);

    logic [NUM_STAGES-1:0] full_reg;
    logic [NUM_STAGES-1:0] full_next;
    logic [NUM_STAGES-1:0] rdy;

    // A stage can load when it is empty or its item moves on
    always_comb
    begin
        rdy[NUM_STAGES-1] = !full_reg[NUM_STAGES-1] || out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = !full_reg[k] || rdy[k+1];
        end
    end

    // Advance occupancy alongside the data
    always_comb
    begin
        full_next[0] = rdy[0] ? in_valid : full_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            full_next[k] = rdy[k] ? full_reg[k-1] : full_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= '0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = full_reg[NUM_STAGES-1];
    assign pipe.load = rdy;
    assign pipe.full = full_reg;

    // Input stalls only when every stage holds an item
    `HSL2RGB_ASSERT_IMPL(a_stall_only_full, clk, rst_n, !in_ready, &full_reg, "input stalled with a free stage")
    // An accepted item occupies the first stage next cycle
    `HSL2RGB_ASSERT_NEXT(a_accept_enters, clk, rst_n, in_valid && in_ready, full_reg[0], "accepted item not captured")
    // Under output stall the last two stages keep their items
    `HSL2RGB_ASSERT_NEXT(a_stall_keeps, clk, rst_n, full_reg[NUM_STAGES-2] && !rdy[NUM_STAGES-1], full_reg[NUM_STAGES-2] && full_reg[NUM_STAGES-1], "item dropped during stall")

endmodule

[src/hsl2rgb_chroma.sv]
// Stages 0 and 1: hue sector and triangle position, chroma product, and the
// c, x and m numerators over the common denominator. Depends on hsl2rgb_pkg.
module hsl2rgb_chroma import hsl2rgb_pkg::*; (
    input  logic             clk,
    input  pipe_ctl_t        pipe,
    input  logic [HUE_W-1:0] hue,
    input  logic [CH_W-1:0]  saturation,
    input  logic [CH_W-1:0]  lightness,
    output sector_t          sector,
    output logic [NUM_W-1:0] cn,
    output logic [NUM_W-1:0] xn,
    output logic [NUM_W-1:0] mn
);

    logic [HUE_W-1:0] hue_wrap;
    logic [HUE_W-1:0] pos;
    logic [TRI_W-1:0] tri_next;
    sector_t          sec_next;
    logic [CH_W-1:0]  a_val;
    logic [P_W-1:0]   p_next;

    sector_t          sec0_reg;
    logic [TRI_W-1:0] tri_reg;
    logic [P_W-1:0]   p_reg;
    logic [CH_W-1:0]  lig_reg;

    sector_t          sec1_reg;
    logic [NUM_W-1:0] cn_reg;
    logic [NUM_W-1:0] xn_reg;
    logic [NUM_W-1:0] mn_reg;

    logic [P_W+TRI_W-1:0] ptri;

    // Wrap hue once and find its sector
    always_comb
    begin
        hue_wrap = (hue >= HUE_FULL) ? (hue - HUE_FULL) : hue;
        priority if (hue_wrap >= HUE_W'(5 * 960))
            sec_next = SEC_MAG_RED;
        else if (hue_wrap >= HUE_W'(4 * 960))
            sec_next = SEC_BLU_MAG;
        else if (hue_wrap >= HUE_W'(3 * 960))
            sec_next = SEC_CYN_BLU;
        else if (hue_wrap >= HUE_W'(2 * 960))
            sec_next = SEC_GRN_CYN;
        else if (hue_wrap >= HUE_SECTOR)
            sec_next = SEC_YEL_GRN;
        else
            sec_next = SEC_RED_YEL;
    end

    // Position within the sector pair, folded into a triangle
    always_comb
    begin
        unique case (sec_next)
            SEC_GRN_CYN, SEC_CYN_BLU: pos = hue_wrap - HUE_PAIR;
            SEC_BLU_MAG, SEC_MAG_RED: pos = hue_wrap - HUE_W'(2 * 1920);
            default:                  pos = hue_wrap;
        endcase
        tri_next = (pos >= HUE_SECTOR) ? TRI_W'(HUE_PAIR - pos) : TRI_W'(pos);
    end

    // Scaled chroma: 255 * (1 - |2l - 1|) times saturation
    always_comb
    begin
        a_val  = lightness[CH_W-1] ? CH_W'(9'd510 - {lightness, 1'b0})
                                   : CH_W'({lightness, 1'b0});
        p_next = P_W'(a_val) * P_W'(saturation);
    end

    always_ff @(posedge clk)
    begin
        if (pipe.load[0])
        begin
            sec0_reg <= sec_next;
            tri_reg  <= tri_next;
            p_reg    <= p_next;
            lig_reg  <= lightness;
        end
    end

    // Numerators for chroma, secondary and offset
    assign ptri = (P_W+TRI_W)'(p_reg) * (P_W+TRI_W)'(tri_reg);

    always_ff @(posedge clk)
    begin
        if (pipe.load[1])
        begin
            sec1_reg <= sec0_reg;
            cn_reg   <= NUM_W'(p_reg) * NUM_W'(1920);
            xn_reg   <= NUM_W'({ptri, 1'b0});
            mn_reg   <= NUM_W'(lig_reg) * NUM_W'(CH_DIVISOR) - NUM_W'(p_reg) * NUM_W'(960);
        end
    end

    assign sector = sec1_reg;
    assign cn     = cn_reg;
    assign xn     = xn_reg;
    assign mn     = mn_reg;

endmodule

[src/hsl2rgb_mix.sv]
// Stage 2: place chroma and secondary on the channels by sector and add
// the offset. Depends on hsl2rgb_pkg.
module hsl2rgb_mix import hsl2rgb_pkg::*; (
    input  logic             clk,
    input  pipe_ctl_t        pipe,
    input  sector_t          sector,
    input  logic [NUM_W-1:0] cn,
    input  logic [NUM_W-1:0] xn,
    input  logic [NUM_W-1:0] mn,
    output logic [NUM_W-1:0] r_num,
    output logic [NUM_W-1:0] g_num,
    output logic [NUM_W-1:0] b_num
);

    logic [NUM_W-1:0] r1;
    logic [NUM_W-1:0] g1;
    logic [NUM_W-1:0] b1;
    logic [NUM_W-1:0] r_reg;
    logic [NUM_W-1:0] g_reg;
    logic [NUM_W-1:0] b_reg;

    // Route c, x and zero per sector
    always_comb
    begin
        unique case (sector)
            SEC_RED_YEL: begin r1 = cn; g1 = xn; b1 = '0; end
            SEC_YEL_GRN: begin r1 = xn; g1 = cn; b1 = '0; end
            SEC_GRN_CYN: begin r1 = '0; g1 = cn; b1 = xn; end
            SEC_CYN_BLU: begin r1 = '0; g1 = xn; b1 = cn; end
            SEC_BLU_MAG: begin r1 = xn; g1 = '0; b1 = cn; end
            default:     begin r1 = cn; g1 = '0; b1 = xn; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pipe.load[2])
        begin
            r_reg <= r1 + mn;
            g_reg <= g1 + mn;
            b_reg <= b1 + mn;
        end
    end

    assign r_num = r_reg;
    assign g_num = g_reg;
    assign b_num = b_reg;

endmodule

[src/hsl2rgb_div.sv]
// Stages 3 and 4: divide one channel numerator by the channel divisor
// through a reciprocal estimate and one correction. Depends on hsl2rgb_pkg.
`include "hsl_to_rgb_converter_unit_macros.svh"

module hsl2rgb_div import hsl2rgb_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  pipe_ctl_t        pipe,
    input  logic [NUM_W-1:0] num,
    output logic [CH_W-1:0]  q
);

    localparam int PROD_W = NUM_W + RECIP_W;

    logic [PROD_W-1:0] prod;
    logic [CH_W-1:0]   est_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [NUM_W-1:0]  rem;
    logic [CH_W-1:0]   q_reg;

    // Estimate quotient, never above the true one and at most one below
    assign prod = PROD_W'(num) * PROD_W'(RECIP_K);

    always_ff @(posedge clk)
    begin
        if (pipe.load[3])
        begin
            est_reg <= prod[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
            num_reg <= num;
        end
    end

    // Correct the estimate by one remainder compare
    assign rem = num_reg - NUM_W'(est_reg) * NUM_W'(CH_DIVISOR);

    always_ff @(posedge clk)
    begin
        if (pipe.load[4])
        begin
            q_reg <= (rem >= NUM_W'(CH_DIVISOR)) ? est_reg + CH_W'(1) : est_reg;
        end
    end

    assign q = q_reg;

    // Numerator stays below 256 divisors so the quotient fits
    `HSL2RGB_ASSERT_IMPL(a_num_range, clk, rst_n, pipe.full[2] && pipe.load[3], num < NUM_W'(256 * 489600), "channel numerator out of range")
    // Estimate is off by at most one
    `HSL2RGB_ASSERT_IMPL(a_est_close, clk, rst_n, pipe.full[3] && pipe.load[4], rem < NUM_W'(2 * 489600), "reciprocal estimate too low")

endmodule

[src/hsl_to_rgb_converter_unit.sv]
// HSL to RGB converter. Takes one item per clock and returns red, green and
// blue through five register stages (sector and chroma product,
// c/x/m numerators, channel mix, reciprocal estimate, correction), each
// holding one item, with the last stage as output register. Sustained rate
// is one item per cycle; output back-pressure stalls stages from the end
// and input ready drops only when all five stages hold an item.
// Depends on hsl2rgb_pkg, the channel interfaces and the submodules.
module hsl_to_rgb_converter_unit import hsl2rgb_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    hsl2rgb_in_if.sink           hsl_in,
    hsl2rgb_out_if.source        rgb_out
);

    pipe_ctl_t        pipe;
    sector_t          sector;
    logic [NUM_W-1:0] cn;
    logic [NUM_W-1:0] xn;
    logic [NUM_W-1:0] mn;
    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] g_num;
    logic [NUM_W-1:0] b_num;

    // Handshake and stage enables
    hsl2rgb_pipe_ctl u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hsl_in.valid),
        .in_ready  (hsl_in.ready),
        .out_valid (rgb_out.valid),
        .out_ready (rgb_out.ready),
        .pipe      (pipe)
    );

    // Chroma, secondary and offset numerators
    hsl2rgb_chroma u_chroma (
        .clk        (clk),
        .pipe       (pipe),
        .hue        (hsl_in.hue),
        .saturation (hsl_in.saturation),
        .lightness  (hsl_in.lightness),
        .sector     (sector),
        .cn         (cn),
        .xn         (xn),
        .mn         (mn)
    );

    // Channel numerators
    hsl2rgb_mix u_mix (
        .clk    (clk),
        .pipe   (pipe),
        .sector (sector),
        .cn     (cn),
        .xn     (xn),
        .mn     (mn),
        .r_num  (r_num),
        .g_num  (g_num),
        .b_num  (b_num)
    );

    // One divider per channel
    hsl2rgb_div u_div_r (
        .clk   (clk),
        .rst_n (rst_n),
        .pipe  (pipe),
        .num   (r_num),
        .q     (rgb_out.red)
    );

    hsl2rgb_div u_div_g (
        .clk   (clk),
        .rst_n (rst_n),
        .pipe  (pipe),
        .num   (g_num),
        .q     (rgb_out.green)
    );

    hsl2rgb_div u_div_b (
        .clk   (clk),
        .rst_n (rst_n),
        .pipe  (pipe),
        .num   (b_num),
        .q     (rgb_out.blue)
    );

endmodule

[tb/tb_hsl_to_rgb_converter_unit.sv]
// Self-checking testbench for hsl_to_rgb_converter_unit: directed and random HSL items,
// each checked against a bit-exact fixed-point prediction of red, green and blue.
// Depends on hsl2rgb_pkg, hsl2rgb_in_if, hsl2rgb_out_if and the converter RTL.
`timescale 1ns / 100ps

module tb_hsl_to_rgb_converter_unit;
    import hsl2rgb_pkg::*;

    localparam int NUM_RANDOM   = 1126;
    localparam int IDLE_LIMIT   = 5000;
    localparam int SETTLE_TICKS = 20;
    localparam int HOLD_AT      = 400;   // results seen before the long receiver hold-off
    localparam int HOLD_CYCLES  = 200;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    typedef struct {
        logic [HUE_W-1:0] hue;
        logic [CH_W-1:0]  sat;
        logic [CH_W-1:0]  lig;
        int               gap;          // idle cycles before the item is offered
        bit               wait_drain;   // hold the item until every result is back
    } hsl_item_t;

    logic clk;
    logic rst_n;

    hsl2rgb_in_if  hsl_in ();
    hsl2rgb_out_if rgb_out ();

    hsl_to_rgb_converter_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .hsl_in  (hsl_in),
        .rgb_out (rgb_out)
    );

    hsl_item_t colors_to_send[$];
    rgb_t      expected_rgb[$];
    int        mismatch_cnt;
    int        in_flight;
    int        rx_count;
    int        rx_stall_left;
    bit        rx_held_off;
    int        idle_cycles;

    // Clock
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Bit-exact RGB for one HSL color; fractions over 2*255*960
    function automatic rgb_t predict_rgb(input logic [HUE_W-1:0] hue,
                                         input logic [CH_W-1:0] sat,
                                         input logic [CH_W-1:0] lig);
        int unsigned     h;
        int unsigned     pos;
        int unsigned     ramp;
        int unsigned     a;
        int unsigned     p;
        longint unsigned chroma;
        longint unsigned second;
        longint unsigned offset;
        longint unsigned r1;
        longint unsigned g1;
        longint unsigned b1;
        sector_t         sec;
        rgb_t            res;

        // wrap hue at 360 degrees
        h = hue;
        if (h >= HUE_FULL)
            h -= HUE_FULL;
        sec  = sector_t'(h / HUE_SECTOR);
        pos  = h % HUE_PAIR;
        ramp = (pos >= HUE_SECTOR) ? (HUE_PAIR - pos) : pos;

        // a = 255 * (1 - |2l - 1|), p = a * s
        a = (lig >= 8'd128) ? (510 - 2 * lig) : (2 * lig);
        p = a * sat;

        chroma = 64'(p) * 64'd1920;
        second = 64'(p) * 64'(ramp) * 64'd2;
        offset = 64'(lig) * 64'(CH_DIVISOR) - 64'(p) * 64'd960;

        case (sec)
            SEC_RED_YEL: begin r1 = chroma; g1 = second; b1 = 0;      end
            SEC_YEL_GRN: begin r1 = second; g1 = chroma; b1 = 0;      end
            SEC_GRN_CYN: begin r1 = 0;      g1 = chroma; b1 = second; end
            SEC_CYN_BLU: begin r1 = 0;      g1 = second; b1 = chroma; end
            SEC_BLU_MAG: begin r1 = second; g1 = 0;      b1 = chroma; end
            default:     begin r1 = chroma; g1 = 0;      b1 = second; end
        endcase

        res.red   = CH_W'((r1 + offset) / CH_DIVISOR);
        res.green = CH_W'((g1 + offset) / CH_DIVISOR);
        res.blue  = CH_W'((b1 + offset) / CH_DIVISOR);
        return res;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;

        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic add_color(input int hue, input int sat, input int lig,
                             input int gap, input bit wait_drain);
        hsl_item_t c;

        c.hue        = HUE_W'(hue);
        c.sat        = CH_W'(sat);
        c.lig        = CH_W'(lig);
        c.gap        = gap;
        c.wait_drain = wait_drain;
        colors_to_send.push_back(c);
    endtask

    function automatic int pick_level();
        int r;

        r = $urandom_range(0, 15);
        case (r)
            0:       return 0;
            1:       return 255;
            2:       return 127;
            3:       return 128;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // Driver: offer queued items, honoring gaps and drain requests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hsl_in.valid      <= 1'b0;
            hsl_in.hue        <= '0;
            hsl_in.saturation <= '0;
            hsl_in.lightness  <= '0;
            in_flight = 0;
        end
        else
        begin
            if (hsl_in.valid && hsl_in.ready)
                in_flight++;
            if (rgb_out.valid && rgb_out.ready)
                in_flight--;

            if (!hsl_in.valid || hsl_in.ready)
            begin
                if (colors_to_send.size() == 0)
                    hsl_in.valid <= 1'b0;
                else if (colors_to_send[0].gap > 0)
                begin
                    colors_to_send[0].gap--;
                    hsl_in.valid <= 1'b0;
                end
                else if (colors_to_send[0].wait_drain && in_flight != 0)
                    hsl_in.valid <= 1'b0;
                else
                begin
                    hsl_in.hue        <= colors_to_send[0].hue;
                    hsl_in.saturation <= colors_to_send[0].sat;
                    hsl_in.lightness  <= colors_to_send[0].lig;
                    hsl_in.valid      <= 1'b1;
                    void'(colors_to_send.pop_front());
                end
            end
        end
    end

    // Receiver: random stalls, a quiet stretch, and one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rgb_out.ready <= 1'b0;
            rx_count      = 0;
            rx_stall_left = 0;
            rx_held_off   = 1'b0;
        end
        else
        begin
            if (rgb_out.valid && rgb_out.ready)
                rx_count++;
            if (!rx_held_off && rx_count >= HOLD_AT)
            begin
                rx_held_off   = 1'b1;
                rx_stall_left = HOLD_CYCLES;
            end

            if (rx_stall_left > 0)
            begin
                rx_stall_left--;
                rgb_out.ready <= 1'b0;
            end
            else
            begin
                rgb_out.ready <= 1'b1;
                // every third stretch of results runs without stalls
                if (((rx_count / 150) % 3) != 1 && $urandom_range(0, 2) == 0)
                    rx_stall_left = idle_len();
            end
        end
    end

    // Monitor: check each result, then record the prediction for a new item
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rgb_out.valid && rgb_out.ready)
            begin
                if (expected_rgb.size() == 0)
                begin
                    $display("%0t: result with no item pending: red %0d green %0d blue %0d",
                             $time, rgb_out.red, rgb_out.green, rgb_out.blue);
                    mismatch_cnt++;
                end
                else
                begin
                    rgb_t want;
                    want = expected_rgb.pop_front();
                    if (rgb_out.red !== want.red)
                    begin
                        $display("%0t: red mismatch: expected %0d actual %0d",
                                 $time, want.red, rgb_out.red);
                        mismatch_cnt++;
                    end
                    if (rgb_out.green !== want.green)
                    begin
                        $display("%0t: green mismatch: expected %0d actual %0d",
                                 $time, want.green, rgb_out.green);
                        mismatch_cnt++;
                    end
                    if (rgb_out.blue !== want.blue)
                    begin
                        $display("%0t: blue mismatch: expected %0d actual %0d",
                                 $time, want.blue, rgb_out.blue);
                        mismatch_cnt++;
                    end
                end
            end

            if (hsl_in.valid && hsl_in.ready)
                expected_rgb.push_back(predict_rgb(hsl_in.hue, hsl_in.saturation,
                                                   hsl_in.lightness));
        end
    end

    // Watchdog: end the run when no item moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((hsl_in.valid && hsl_in.ready) || (rgb_out.valid && rgb_out.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        int hue;
        int k;

        rst_n             = 1'b0;
        hsl_in.valid      = 1'b0;
        hsl_in.hue        = '0;
        hsl_in.saturation = '0;
        hsl_in.lightness  = '0;
        rgb_out.ready     = 1'b0;
        mismatch_cnt      = 0;
        idle_cycles       = 0;

        // extremes, sector edges, hue wrap, zero saturation, black and white
        add_color(0,    255, 128, 0, 1'b0);
        add_color(959,  255, 128, 0, 1'b0);
        add_color(960,  255, 128, 0, 1'b0);
        add_color(1919, 255, 128, 0, 1'b0);
        add_color(1920, 255, 128, 0, 1'b0);
        add_color(2880, 255, 127, 0, 1'b0);
        add_color(3840, 255, 127, 0, 1'b0);
        add_color(4800, 255, 127, 0, 1'b0);
        add_color(5759, 255, 128, 0, 1'b0);
        add_color(5760, 255, 128, 0, 1'b0);
        add_color(8191, 255, 255, 0, 1'b0);
        add_color(6720, 200, 100, 0, 1'b0);
        add_color(1000, 0,   0,   0, 1'b0);
        add_color(1000, 0,   200, 0, 1'b0);
        add_color(3000, 0,   255, 0, 1'b0);
        add_color(4000, 255, 0,   0, 1'b0);
        add_color(5000, 255, 255, 0, 1'b0);
        add_color(480,  128, 64,  0, 1'b0);
        add_color(1440, 64,  192, 0, 1'b0);
        add_color(2400, 255, 1,   0, 1'b0);
        add_color(3360, 1,   254, 0, 1'b0);
        add_color(4320, 170, 85,  0, 1'b0);
        add_color(5280, 85,  170, 0, 1'b0);
        add_color(4095, 127, 127, 0, 1'b0);

        // random colors; now and then wait for the pipe to empty first
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            k = $urandom_range(0, 9);
            if (k == 0)
                hue = $urandom_range(5760, 8191);
            else if (k == 1)
                hue = $urandom_range(1, 5) * 960 - 1 + $urandom_range(0, 2);
            else
                hue = $urandom_range(0, 5759);
            add_color(hue, pick_level(), pick_level(), idle_len(),
                      (i == 0) || (i % 250 == 125));
        end

        // reset
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // wait for all items to go in and all results to come back
        while (colors_to_send.size() != 0 || hsl_in.valid)
            @(negedge clk);
        while (expected_rgb.size() != 0)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(negedge clk);

        if (mismatch_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
